// ----- rtl/mpf_pkg.sv -----
// Shared constants and helpers for the five-stage add/addi pipeline.
// Used by the pipeline top level; no dependencies.

package mpf_pkg;

	localparam int REG_COUNT = 32;
	localparam int ADDR_W    = $clog2(REG_COUNT);
	localparam int IDX_W     = 5;
	localparam int DATA_W    = 32;

	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_ADDI  = 6'h08;
	localparam logic [5:0] FN_ADD   = 6'h20;

	// index names an existing register
	function automatic logic in_range(input logic [IDX_W-1:0] idx);
		return {1'b0, idx} < (IDX_W + 1)'(REG_COUNT);
	endfunction

	// index may be written: existing and not r0
	function automatic logic dest_ok(input logic [IDX_W-1:0] idx);
		return (idx != '0) && in_range(idx);
	endfunction

endpackage

// ----- rtl/mpf_ram.sv -----
// Generic RAM: one write port, two read ports, registered read data.
// No package dependencies; contents undefined until written.

module mpf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ----- rtl/mips_pipeline_with_forwarding.sv -----
// Five-stage add/addi pipeline with EX and MEM forwarding.
// Depends on mpf_pkg and mpf_ram (register file storage).
//
// Usage:
//   Input channel (in_valid/in_ready, instr_word) takes one fetched
//   instruction word per transfer; a zero word is a bubble. Each input
//   transfer advances every stage latch by one stage, so the pipeline moves
//   only on input transfers, one per clock at full rate.
//   Output channel (out_valid/out_ready, wb_valid/wb_reg/wb_data) carries
//   one register write-back. The write retired by the instruction of input
//   transfer k is offered after input transfer k+4, from an output register.
//   Throughput is one instruction per cycle while input is taken; the
//   single EX adder and its forwarding muxes sit between ID/EX and EX/MEM.
//   When the receiver stalls, input is still taken as long as the next
//   step retires nothing; a step that retires a write waits until the
//   pending result is taken or is taken in the same cycle.
//   Reset (arst_n low) clears all stage controls, marks every register
//   file entry as zero through valid bits and empties the output register.
//   Words other than add and addi, and writes to r0, retire nothing.

module mips_pipeline_with_forwarding
	import mpf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       instr_word,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              wb_valid,
	output logic [IDX_W-1:0]  wb_reg,
	output logic [DATA_W-1:0] wb_data
);

	// IF/ID
	logic [31:0]        ifid_s1;
	// ID/EX
	logic               idex_we_s2;
	logic               alusrc_s2;
	logic               regdst_s2;
	logic [IDX_W-1:0]   rs_s2, rt_s2, rd_s2;
	logic [DATA_W-1:0]  imm_s2;
	logic               byp_a_s2, byp_b_s2;
	logic               zero_a_s2, zero_b_s2;
	logic [DATA_W-1:0]  wdata_s2;
	// EX/MEM, MEM/WB
	logic               exmem_we_s3;
	logic [IDX_W-1:0]   exmem_dest_s3;
	logic [DATA_W-1:0]  exmem_val_s3;
	logic               memwb_we_s4;
	logic [IDX_W-1:0]   memwb_dest_s4;
	logic [DATA_W-1:0]  memwb_val_s4;

	logic [REG_COUNT-1:0] vld_q;
	logic                 out_valid_q;
	logic [IDX_W-1:0]     wb_reg_q;
	logic [DATA_W-1:0]    wb_data_q;

	logic               step;
	logic               rf_we;
	logic [5:0]         op_id, fn_id;
	logic [IDX_W-1:0]   rs_id, rt_id, rd_id, dest_id;
	logic               is_add, is_addi, we_id;
	logic               src_a_ok, src_b_ok;
	logic [DATA_W-1:0]  ram_a, ram_b;
	logic [DATA_W-1:0]  data1, data2, opa, opb, second;

	assign in_ready = !out_valid_q || out_ready || !memwb_we_s4;
	assign step     = in_valid && in_ready;
	assign rf_we    = step && memwb_we_s4 && dest_ok(memwb_dest_s4);

	// decode
	assign op_id   = ifid_s1[31:26];
	assign fn_id   = ifid_s1[5:0];
	assign rs_id   = ifid_s1[25:21];
	assign rt_id   = ifid_s1[20:16];
	assign rd_id   = ifid_s1[15:11];
	assign is_add  = (ifid_s1 != '0) && (op_id == OP_RTYPE) && (fn_id == FN_ADD);
	assign is_addi = (op_id == OP_ADDI);
	assign dest_id = is_add ? rd_id : rt_id;
	assign we_id   = (is_add || is_addi) && dest_ok(dest_id);

	assign src_a_ok = in_range(rs_id) && vld_q[rs_id[ADDR_W-1:0]];
	assign src_b_ok = in_range(rt_id) && vld_q[rt_id[ADDR_W-1:0]];

	mpf_ram #(
		.WIDTH(DATA_W),
		.DEPTH(REG_COUNT)
	) u_rf (
		.clk    (clk),
		.we     (rf_we),
		.waddr  (memwb_dest_s4[ADDR_W-1:0]),
		.wdata  (memwb_val_s4),
		.re     (step),
		.raddr_a(rs_id[ADDR_W-1:0]),
		.raddr_b(rt_id[ADDR_W-1:0]),
		.rdata_a(ram_a),
		.rdata_b(ram_b)
	);

	// register file value as seen in ID, write-before-read
	assign data1 = byp_a_s2 ? wdata_s2 : (zero_a_s2 ? '0 : ram_a);
	assign data2 = byp_b_s2 ? wdata_s2 : (zero_b_s2 ? '0 : ram_b);

	always_comb begin
		if (exmem_we_s3 && exmem_dest_s3 != '0 && exmem_dest_s3 == rs_s2) begin
			opa = exmem_val_s3;
		end else if (memwb_we_s4 && memwb_dest_s4 != '0 && memwb_dest_s4 == rs_s2) begin
			opa = memwb_val_s4;
		end else begin
			opa = data1;
		end
		if (exmem_we_s3 && exmem_dest_s3 != '0 && exmem_dest_s3 == rt_s2) begin
			opb = exmem_val_s3;
		end else if (memwb_we_s4 && memwb_dest_s4 != '0 && memwb_dest_s4 == rt_s2) begin
			opb = memwb_val_s4;
		end else begin
			opb = data2;
		end
	end

	assign second = alusrc_s2 ? imm_s2 : opb;

	// stage controls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ifid_s1     <= '0;
			idex_we_s2  <= 1'b0;
			exmem_we_s3 <= 1'b0;
			memwb_we_s4 <= 1'b0;
			vld_q       <= '0;
		end else if (step) begin
			ifid_s1     <= instr_word;
			idex_we_s2  <= we_id;
			exmem_we_s3 <= idex_we_s2;
			memwb_we_s4 <= exmem_we_s3;
			if (rf_we) begin
				vld_q[memwb_dest_s4[ADDR_W-1:0]] <= 1'b1;
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (step) begin
			alusrc_s2     <= is_addi;
			regdst_s2     <= is_add;
			rs_s2         <= rs_id;
			rt_s2         <= rt_id;
			rd_s2         <= rd_id;
			imm_s2        <= {{16{ifid_s1[15]}}, ifid_s1[15:0]};
			byp_a_s2      <= rf_we && (memwb_dest_s4 == rs_id);
			byp_b_s2      <= rf_we && (memwb_dest_s4 == rt_id);
			zero_a_s2     <= !src_a_ok;
			zero_b_s2     <= !src_b_ok;
			wdata_s2      <= memwb_val_s4;
			exmem_dest_s3 <= regdst_s2 ? rd_s2 : rt_s2;
			exmem_val_s3  <= opa + second;
			memwb_dest_s4 <= exmem_dest_s3;
			memwb_val_s4  <= exmem_val_s3;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rf_we) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) begin
			wb_reg_q  <= memwb_dest_s4;
			wb_data_q <= memwb_val_s4;
		end
	end

	assign out_valid = out_valid_q;
	assign wb_valid  = out_valid_q;
	assign wb_reg    = wb_reg_q;
	assign wb_data   = wb_data_q;

endmodule

// ----- rtl/mpf_checker.sv -----
// Port-level checks for the add/addi pipeline top level.
// Depends on mpf_pkg; bound to mips_pipeline_with_forwarding below.

module mpf_checker
	import mpf_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [31:0]       instr_word,
	input logic              out_valid,
	input logic              out_ready,
	input logic              wb_valid,
	input logic [IDX_W-1:0]  wb_reg,
	input logic [DATA_W-1:0] wb_data
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(wb_reg) && $stable(wb_data))
		else $error("result changed while stalled");

	// waiting instruction word holds until its transfer
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(instr_word))
		else $error("instruction word changed while waiting");

	// r0 is never written back
	a_no_r0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> wb_valid && wb_reg != '0)
		else $error("write-back to r0 or without wb_valid");

	// a fresh result only comes from a pipeline step
	a_new_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && $past(!out_valid || out_ready) |-> $past(in_valid && in_ready))
		else $error("result appeared without an input transfer");

	// an empty output register never blocks input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

endmodule

bind mips_pipeline_with_forwarding mpf_checker u_mpf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.instr_word(instr_word),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.wb_valid  (wb_valid),
	.wb_reg    (wb_reg),
	.wb_data   (wb_data)
);

// ----- verif/pipe_wb_checker.sv -----
// Write-back checker for the add/addi pipeline: predicts register write-backs
// from accepted instruction words and compares them with the output channel.
// Depends on mpf_pkg for widths, opcodes and the register count.

module pipe_wb_checker
	import mpf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [31:0]       instr_word,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic              wb_valid,
	input  logic [IDX_W-1:0]  wb_reg,
	input  logic [DATA_W-1:0] wb_data,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic              we;
		logic              use_imm;
		logic              dst_rd;
		logic [IDX_W-1:0]  rs;
		logic [IDX_W-1:0]  rt;
		logic [IDX_W-1:0]  rd;
		logic [DATA_W-1:0] opa;
		logic [DATA_W-1:0] opb;
		logic [DATA_W-1:0] imm;
	} issue_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  dst;
		logic [DATA_W-1:0] val;
	} result_t;

	typedef struct packed {
		logic [IDX_W-1:0]  reg_idx;
		logic [DATA_W-1:0] data;
	} reg_write_t;

	logic [DATA_W-1:0] gpr [REG_COUNT];
	logic [31:0]       fetched;
	issue_t            issued;
	result_t           executed;
	result_t           retiring;
	reg_write_t        writes_due [$];
	reg_write_t        head;
	int                errs;

	assign fail_count = errs;

	function automatic logic writable(input logic [IDX_W-1:0] idx);
		return idx != '0 && int'(idx) < REG_COUNT;
	endfunction

	function automatic logic [DATA_W-1:0] read_gpr(input logic [IDX_W-1:0] idx);
		if (int'(idx) >= REG_COUNT)
			return '0;
		return gpr[idx];
	endfunction

	// EX/MEM wins over MEM/WB; r0 is never forwarded
	function automatic logic [DATA_W-1:0] forward(input logic [IDX_W-1:0] src,
			input logic [DATA_W-1:0] reg_val);
		if (executed.we && executed.dst != '0 && executed.dst == src)
			return executed.val;
		if (retiring.we && retiring.dst != '0 && retiring.dst == src)
			return retiring.val;
		return reg_val;
	endfunction

	task automatic advance_pipeline(input logic [31:0] w);
		issue_t            nx_issue;
		result_t           nx_exec;
		reg_write_t        wr;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [5:0]        opc;
		logic [IDX_W-1:0]  rs;
		logic [IDX_W-1:0]  rt;
		logic [IDX_W-1:0]  rd;
		logic              is_add;
		logic              is_addi;

		// WB: write lands before the ID read below
		if (retiring.we && writable(retiring.dst)) begin
			gpr[retiring.dst] = retiring.val;
			wr.reg_idx = retiring.dst;
			wr.data = retiring.val;
			writes_due.push_back(wr);
		end

		a = forward(issued.rs, issued.opa);
		b = forward(issued.rt, issued.opb);
		nx_exec.we = issued.we;
		nx_exec.dst = issued.dst_rd ? issued.rd : issued.rt;
		nx_exec.val = a + (issued.use_imm ? issued.imm : b);

		nx_issue = '0;
		opc = fetched[31:26];
		rs = fetched[25:21];
		rt = fetched[20:16];
		rd = fetched[15:11];
		is_add = fetched != '0 && opc == OP_RTYPE && fetched[5:0] == FN_ADD;
		is_addi = fetched != '0 && opc == OP_ADDI;
		if (is_add) begin
			nx_issue.we = writable(rd);
			nx_issue.dst_rd = 1'b1;
		end else if (is_addi) begin
			nx_issue.we = writable(rt);
			nx_issue.use_imm = 1'b1;
		end
		if (nx_issue.we) begin
			nx_issue.rs = rs;
			nx_issue.rt = rt;
			nx_issue.rd = rd;
			nx_issue.opa = read_gpr(rs);
			nx_issue.opb = read_gpr(rt);
			nx_issue.imm = {{16{fetched[15]}}, fetched[15:0]};
		end else begin
			nx_issue = '0;
		end

		fetched = w;
		retiring = executed;
		executed = nx_exec;
		issued = nx_issue;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++)
				gpr[i] = '0;
			fetched = '0;
			issued = '0;
			executed = '0;
			retiring = '0;
			writes_due.delete();
			errs = 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready)
				advance_pipeline(instr_word);
			if (out_valid && out_ready) begin
				if (writes_due.size() == 0) begin
					$error("write-back transfer with none expected: wb_reg %0d wb_data %h",
						wb_reg, wb_data);
					errs++;
				end else begin
					head = writes_due.pop_front();
					if (wb_valid !== 1'b1) begin
						$error("wb_valid: expected 1, got %b", wb_valid);
						errs++;
					end
					if (wb_reg !== head.reg_idx) begin
						$error("wb_reg: expected %0d, got %0d", head.reg_idx, wb_reg);
						errs++;
					end
					if (wb_data !== head.data) begin
						$error("wb_data: expected %h, got %h", head.data, wb_data);
						errs++;
					end
				end
			end
			pending <= writes_due.size();
		end
	end

endmodule

// ----- verif/testbench.sv -----
// Top of the pipeline testbench: clock, reset, instruction stimulus with
// bursty input and stalling output, watchdog and verdict.
// Depends on mpf_pkg, mips_pipeline_with_forwarding and pipe_wb_checker.

module testbench;
	import mpf_pkg::*;

	localparam int EXEC_ITEMS = 1000;
	localparam int IDLE_LIMIT = 2000;
	localparam logic [5:0] OP_J   = 6'h02;
	localparam logic [5:0] OP_LW  = 6'h23;
	localparam logic [5:0] FN_SUB = 6'h22;

	typedef enum {RX_OPEN, RX_RANDOM, RX_BLOCKED} rx_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [31:0]       instr_word = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              wb_valid;
	logic [IDX_W-1:0]  wb_reg;
	logic [DATA_W-1:0] wb_data;
	int                fail_count;
	int                pending;
	int                idle_cycles = 0;
	int                burst_left = 0;
	rx_mode_t          rx_mode = RX_OPEN;
	int                rx_left = 0;

	mips_pipeline_with_forwarding u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.instr_word (instr_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.wb_valid   (wb_valid),
		.wb_reg     (wb_reg),
		.wb_data    (wb_data)
	);

	pipe_wb_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.instr_word (instr_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.wb_valid   (wb_valid),
		.wb_reg     (wb_reg),
		.wb_data    (wb_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver: open, coin-flip or blocked stretches; a block is never chained
	always @(posedge clk) begin
		if (rx_left == 0) begin
			if (rx_mode == RX_BLOCKED)
				rx_mode = $urandom_range(0, 1) ? RX_OPEN : RX_RANDOM;
			else
				rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_left = (rx_mode == RX_BLOCKED) ? $urandom_range(1, 12) : $urandom_range(1, 40);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN:    out_ready <= 1'b1;
			RX_RANDOM:  out_ready <= $urandom_range(0, 1);
			default:    out_ready <= 1'b0;
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic [31:0] add_op(input logic [4:0] rd, input logic [4:0] rs,
			input logic [4:0] rt, input logic [4:0] shamt);
		return {OP_RTYPE, rs, rt, rd, shamt, FN_ADD};
	endfunction

	function automatic logic [31:0] addi_op(input logic [4:0] rt, input logic [4:0] rs,
			input logic [15:0] imm);
		return {OP_ADDI, rs, rt, imm};
	endfunction

	// small pool most of the time so dependences are frequent
	function automatic logic [4:0] pick_reg();
		return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
	endfunction

	function automatic logic [15:0] pick_imm();
		case ($urandom_range(0, 9))
			0:       return 16'h0000;
			1:       return 16'h7FFF;
			2:       return 16'h8000;
			3:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// one instruction transfer; sender runs in bursts with random gaps
	task automatic feed(input logic [31:0] w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		instr_word <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	// bubbles push every in-flight write out, then wait for the last transfer
	task automatic drain_pipeline();
		repeat (4) feed(32'h0);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		int          n_exec;
		int          pick;
		logic        drained_once;
		logic [31:0] w;
		logic [5:0]  opc;
		logic [5:0]  fn;

		n_exec = 0;
		drained_once = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		feed(addi_op(5'd1, 5'd0, 16'h7FFF));
		feed(addi_op(5'd2, 5'd0, 16'h8000));
		feed(addi_op(5'd3, 5'd1, 16'hFFFF));
		feed(add_op(5'd4, 5'd1, 5'd2, 5'd0));
		feed(add_op(5'd5, 5'd4, 5'd4, 5'd0));
		feed(add_op(5'd6, 5'd5, 5'd4, 5'd0));
		feed(addi_op(5'd7, 5'd0, 16'h0000));
		feed(32'h0);
		feed(add_op(5'd0, 5'd1, 5'd2, 5'd0));
		feed(addi_op(5'd0, 5'd1, 16'h0005));
		// r0 must read zero right after discarded writes to it
		feed(add_op(5'd8, 5'd0, 5'd0, 5'd0));
		feed({OP_RTYPE, 5'd1, 5'd2, 5'd9, 5'd0, FN_SUB});
		feed({OP_J, 26'h0000010});
		feed({OP_LW, 5'd1, 5'd9, 16'h0004});
		feed(32'hFFFF_FFFF);
		feed(addi_op(5'd11, 5'd0, 16'hFFFF));
		feed(add_op(5'd12, 5'd11, 5'd11, 5'h1F));
		feed(add_op(5'd13, 5'd12, 5'd2, 5'd0));
		// distance three: operand comes through the register file
		feed(addi_op(5'd14, 5'd0, 16'h1234));
		feed(32'h0);
		feed(32'h0);
		feed(add_op(5'd15, 5'd14, 5'd14, 5'd0));
		feed(addi_op(5'd31, 5'd31, 16'h0001));
		feed(add_op(5'd31, 5'd31, 5'd13, 5'd0));

		while (n_exec < EXEC_ITEMS) begin
			if (n_exec == EXEC_ITEMS / 2 && !drained_once) begin
				drain_pipeline();
				drained_once = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				w = add_op(pick_reg(), pick_reg(), pick_reg(), 5'($urandom));
				n_exec++;
			end else if (pick < 85) begin
				w = addi_op(pick_reg(), pick_reg(), pick_imm());
				n_exec++;
			end else if (pick < 89) begin
				w = '0;
			end else if (pick < 94) begin
				w = $urandom;
			end else if (pick < 97) begin
				fn = 6'($urandom);
				if (fn == FN_ADD)
					fn = FN_SUB;
				w = {OP_RTYPE, 20'($urandom), fn};
			end else begin
				opc = 6'($urandom_range(1, 63));
				if (opc == OP_ADDI)
					opc = OP_LW;
				w = {opc, 26'($urandom)};
			end
			feed(w);
		end

		drain_pipeline();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
